>>> sv/rbrf_pkg.sv
package rbrf_pkg;

   typedef enum logic [1:0] {
      ACT_BIND   = 2'd0,
      ACT_UNBIND = 2'd1,
      ACT_ENABLE = 2'd2,
      ACT_ACCEPT = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      DEC_ACCEPTED = 3'd0,
      DEC_UNKNOWN  = 3'd1,
      DEC_DISABLED = 3'd2,
      DEC_INVALID  = 3'd3,
      DEC_DENIED   = 3'd4,
      DEC_REPLAY   = 3'd5
   } decision_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

   localparam int IDENT_W = 48;
   localparam int PERM_W  = 6;
   localparam int CTR_W   = 32;
   localparam logic [2:0] CMD_LIMIT = 3'd6;

   typedef struct packed {
      logic [IDENT_W-1:0] ident;
      logic [PERM_W-1:0]  perms;
      logic               enabled;
      logic               replay_req;
      logic               ctr_seen;
      logic [CTR_W-1:0]   last_ctr;
   } entry_type;

endpackage

>>> sv/remote_binding_replay_filter_core.sv
// Remote binding table with replay filter.
// Input channel: a transaction is taken when start is high and busy is low; the
// req_ ports carry the action, the remote identity and the per-action fields.
// Result channel: exactly one result per transaction, shown on the rsp_ ports
// for one cycle while rsp_valid is high. The receiver cannot stall it.
// The table lives in one synchronous memory of MAX_REMOTES entries with a
// registered read port. Each transaction scans the entries below the count,
// one read per cycle, until a match is found or the count is reached.
// Bind, set enable and accept write back at most one entry; unbind copies every
// later entry down by one, via a read state and a write state per moved entry.
// Busy stays high through the result cycle, and the next transaction can be
// taken in the cycle after it; one transaction is in flight at a time.
// Reset clears the entry count and the control state; memory contents need
// no clearing because entries at or above the count are never read.
module remote_binding_replay_filter_core import rbrf_pkg::*; #(
   parameter int MAX_REMOTES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_action,
   input  logic [IDENT_W-1:0]  req_remote_id,
   input  logic [PERM_W-1:0]   req_perm_mask,
   input  logic                req_name_present,
   input  logic                req_replay_required,
   input  logic                req_enable_flag,
   input  logic [2:0]          req_command_code,
   input  logic                req_ctr_present,
   input  logic [CTR_W-1:0]    req_counter,
   output logic                rsp_valid,
   output logic                rsp_op_ok,
   output logic [2:0]          rsp_decision,
   output logic                rsp_entry_found,
   output logic [3:0]          rsp_slot,
   output logic                rsp_command_known
);

   localparam int AW = (MAX_REMOTES > 1) ? $clog2(MAX_REMOTES) : 1;
   localparam int CW = $clog2(MAX_REMOTES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REMOTES);

   entry_type mem [MAX_REMOTES];
   entry_type rd_data_ff;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] hit_ff, hit_in;
   logic found_ff, found_in;
   logic rd_pend_ff, rd_pend_in;

   action_type act_ff;
   logic [IDENT_W-1:0] id_ff;
   logic [PERM_W-1:0] perm_ff;
   logic name_ff, replay_ff, en_ff, cvalid_ff;
   logic [2:0] cmd_ff;
   logic [CTR_W-1:0] ctr_ff;

   logic ok_ff, ok_in, known_ff, known_in;
   logic [2:0] dec_ff, dec_in;

   logic rd_en;
   logic [AW-1:0] rd_addr;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   entry_type wr_data;
   logic accept_in;

   assign accept_in = start && !busy;
   assign busy = state_ff != ST_IDLE;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      hit_ff   <= hit_in;
      found_ff <= found_in;
      ok_ff    <= ok_in;
      dec_ff   <= dec_in;
      known_ff <= known_in;
      if (accept_in) begin
         act_ff    <= action_type'(req_action);
         id_ff     <= req_remote_id;
         perm_ff   <= req_perm_mask;
         name_ff   <= req_name_present;
         replay_ff <= req_replay_required;
         en_ff     <= req_enable_flag;
         cmd_ff    <= req_command_code;
         cvalid_ff <= req_ctr_present;
         ctr_ff    <= req_counter;
      end
   end

   always_comb begin
      entry_type e;
      logic permit;
      e          = rd_data_ff;
      permit     = 1'b0;
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      hit_in     = hit_ff;
      found_in   = found_ff;
      rd_pend_in = 1'b0;
      ok_in      = ok_ff;
      dec_in     = dec_ff;
      known_in   = known_ff;
      rd_en      = 1'b0;
      rd_addr    = idx_ff[AW-1:0];
      wr_en      = 1'b0;
      wr_addr    = hit_ff[AW-1:0];
      wr_data    = rd_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept_in) begin
               idx_in   = '0;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_pend_ff && rd_data_ff.ident == id_ff) begin
               found_in = 1'b1;
               hit_in   = idx_ff - CW'(1);
               state_in = ST_EXEC;
            end else if (idx_ff >= count_ff) begin
               state_in = ST_EXEC;
            end else begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               idx_in     = idx_ff + CW'(1);
            end
         end
         ST_EXEC: begin
            ok_in    = 1'b0;
            dec_in   = DEC_ACCEPTED;
            known_in = 1'b0;
            state_in = ST_DONE;
            case (act_ff)
               ACT_BIND: begin
                  if (perm_ff != '0 && name_ff && (found_ff || count_ff < MAX_CNT)) begin
                     ok_in = 1'b1;
                     wr_en = 1'b1;
                     if (!found_ff) begin
                        wr_addr  = count_ff[AW-1:0];
                        hit_in   = count_ff;
                        count_in = count_ff + CW'(1);
                     end
                     wr_data.ident      = id_ff;
                     wr_data.perms      = perm_ff;
                     wr_data.enabled    = 1'b1;
                     wr_data.replay_req = replay_ff;
                     wr_data.ctr_seen   = 1'b0;
                     wr_data.last_ctr   = '0;
                  end
               end
               ACT_UNBIND: begin
                  if (found_ff) begin
                     ok_in  = 1'b1;
                     idx_in = hit_ff + CW'(1);
                     state_in = ST_SHIFT_RD;
                  end
               end
               ACT_ENABLE: begin
                  if (found_ff) begin
                     ok_in           = 1'b1;
                     wr_en           = 1'b1;
                     wr_data.enabled = en_ff;
                  end
               end
               default: begin
                  known_in = cmd_ff < CMD_LIMIT;
                  if (!found_ff) begin
                     dec_in = DEC_UNKNOWN;
                  end else if (!e.enabled) begin
                     dec_in = DEC_DISABLED;
                  end else if (cmd_ff >= CMD_LIMIT) begin
                     dec_in = DEC_INVALID;
                  end else begin
                     permit = e.perms[cmd_ff];
                     if (!permit) begin
                        dec_in = DEC_DENIED;
                     end else if (e.replay_req) begin
                        if (!cvalid_ff || (e.ctr_seen && ctr_ff <= e.last_ctr)) begin
                           dec_in = DEC_REPLAY;
                        end else begin
                           wr_en            = 1'b1;
                           wr_data.ctr_seen = 1'b1;
                           wr_data.last_ctr = ctr_ff;
                        end
                     end else if (cvalid_ff) begin
                        if (e.ctr_seen && ctr_ff == e.last_ctr) begin
                           dec_in = DEC_REPLAY;
                        end else begin
                           wr_en            = 1'b1;
                           wr_data.ctr_seen = 1'b1;
                           wr_data.last_ctr = ctr_ff;
                        end
                     end
                  end
               end
            endcase
         end
         ST_SHIFT_RD: begin
            if (idx_ff >= count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(idx_ff - CW'(1));
            idx_in   = idx_ff + CW'(1);
            state_in = ST_SHIFT_RD;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      logic show;
      show              = state_ff == ST_DONE;
      rsp_valid         = show;
      rsp_op_ok         = ok_ff;
      rsp_decision      = (act_ff == ACT_ACCEPT) ? dec_ff : DEC_ACCEPTED;
      rsp_entry_found   = (act_ff == ACT_ACCEPT) && found_ff;
      rsp_slot          = (act_ff == ACT_ACCEPT && found_ff) ? 4'(hit_ff) : 4'd0;
      rsp_command_known = known_ff;
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT) else $error("entry count above table size");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(state_ff == ST_EXEC || state_ff == ST_SHIFT_RD))
      else $error("entry count changed outside update");
   a_busy_until_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy held after result");
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) < MAX_CNT)) else $error("write beyond table");
`endif

endmodule
